>>> src/mrg_pkg.sv
// Shared types and constants of the minimal-standard random range generator.
package mrg_pkg;

    // Generator modulus (the Mersenne prime 2^31 - 1), multiplier and reset seed.
    localparam int STATE_W = 31;
    localparam logic [STATE_W-1:0] MOD = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] RESET_SEED = 31'd123456789;
    localparam int MUL_W = 16;
    localparam logic [MUL_W-1:0] MUL = 16'd48271;

    // Serial multiplier: the multiplier operand is scanned from its top bit down.
    localparam int MULT_W = 33;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] ADV_BITS = 6'(MUL_W);
    localparam logic [CNT_W-1:0] SPAN_BITS = 6'(MULT_W);
    localparam logic [MULT_W-1:0] MUL_ALIGNED = {MUL, {(MULT_W-MUL_W){1'b0}}};

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_SEED     = 3'd0,
        OP_RAW      = 3'd1,
        OP_COIN     = 3'd2,
        OP_ONE_TO_N = 3'd3,
        OP_RANGE    = 3'd4
    } op_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_SCALE,
        ST_COMBINE,
        ST_DONE
    } state_t;

    // Command from the sequencer to the serial multiplier.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } mm_cmd_t;

    // Status from the serial multiplier back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

>>> src/mrg_mulmod.sv
// Bit-serial multiplier that forms quotient and remainder of a product by 2^31 - 1.
module mrg_mulmod
    import mrg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mm_cmd_t             cmd,
    input  logic [STATE_W-1:0]  multiplicand,  // 0 .. 2^31 - 1
    input  logic [MULT_W-1:0]   multiplier,    // left aligned, top bit first
    output mm_status_t          status,
    output logic [STATE_W-1:0]  rem,
    output logic [MULT_W-1:0]   quo
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic [MULT_W-1:0]  mult_reg;
    logic [STATE_W-1:0] mcand_reg;
    logic [STATE_W-1:0] r_reg;
    logic [MULT_W-1:0]  q_reg;

    logic [STATE_W-1:0] rot;
    logic [STATE_W:0]   sum;
    logic               wrap;
    logic [STATE_W-1:0] r_step;
    logic [MULT_W-1:0]  q_step;

    // Doubling modulo 2^31 - 1 is a rotation; the bit that wraps adds one to the quotient.
    always_comb
    begin
        rot    = {r_reg[STATE_W-2:0], r_reg[STATE_W-1]};
        sum    = {1'b0, rot} + (mult_reg[MULT_W-1] ? {1'b0, mcand_reg} : '0);
        wrap   = (sum >= {1'b0, MOD});
        r_step = wrap ? STATE_W'(sum - {1'b0, MOD}) : sum[STATE_W-1:0];
        q_step = {q_reg[MULT_W-2:0], 1'b0} + MULT_W'(r_reg[STATE_W-1]) + MULT_W'(wrap);
    end

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        if (cmd.start)
        begin
            count_next = cmd.nbits;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mult_reg  <= multiplier;
            mcand_reg <= multiplicand;
            r_reg     <= '0;
            q_reg     <= '0;
        end
        else if (count_reg != '0)
        begin
            mult_reg <= {mult_reg[MULT_W-2:0], 1'b0};
            r_reg    <= r_step;
            q_reg    <= q_step;
        end
    end

    assign status.busy = (count_reg != '0);
    assign status.done = done_reg;
    assign rem = r_reg;
    assign quo = q_reg;

`ifndef ASSERT_OFF
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg != MOD))
        else $error("remainder not reduced below the modulus");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (count_reg == '0))
        else $error("multiply started while busy");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg != '0) && !cmd.start) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("step counter skipped");
`endif

endmodule

>>> src/minstd_random_range_generator.sv
// Top level of the minimal-standard random range generator with its request sequencer.

// The block holds a Park-Miller generator state, advanced as state = 48271 * state
// mod 2^31 - 1, and answers one request at a time with one result. A seed request
// loads the reduced seed and passes through the done state to the output register;
// a raw draw or a coin makes one pass through the single bit-serial modular
// multiplier to advance the state, and a one-to-N or two-bound range draw makes a
// second pass to scale the result. The multiplier works through one bit of 48271 (16 bits)
// per cycle to advance the state and one bit of the 33-bit span per cycle to scale the
// result. A finished result waits in an output register, so the next request is
// accepted while it is still waiting to be taken; a further finished result holds the
// sequencer until the waiting one has been taken. Operation codes five to seven leave
// the state alone and return the current state with a scaled value of zero.
module minstd_random_range_generator
    import mrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [30:0] new_state, [63:31] scaled_value
);

    state_t state_reg, state_next;

    logic [2:0]         op_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        mag_reg;
    logic               sp_reg;
    logic [STATE_W-1:0] gen_state_reg;
    logic [33:0]        base_reg;
    logic               rnz_reg;

    logic               out_valid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic [32:0]        out_value_reg;

    mm_cmd_t            mm_cmd;
    mm_status_t         mm_status;
    logic [STATE_W-1:0] mm_mcand;
    logic [MULT_W-1:0]  mm_mult;
    logic [STATE_W-1:0] mm_rem;
    logic [MULT_W-1:0]  mm_quo;

    logic               accept;
    logic               load_out;
    logic               op_draws;
    logic               op_scales;
    logic               req_draws;

    // Decoded operands of an incoming request.
    logic [31:0]        a_in;
    logic [31:0]        b_in;
    logic [32:0]        d_ab;
    logic [32:0]        d_ba;
    logic               a_lt_b;
    logic [31:0]        abs_a;
    logic [STATE_W-1:0] seed_dec;
    logic [STATE_W-1:0] seed_low_m1;

    logic [STATE_W-1:0] adv_state;
    logic [33:0]        lo_ext;
    logic [33:0]        q_ext;
    logic [33:0]        value_adj;

    assign accept = s_tvalid && s_tready;
    assign a_in = s_tdata[31:0];
    assign b_in = s_tdata[63:32];

    // An incoming request that advances the generator.
    assign req_draws = s_tuser inside {OP_RAW, OP_COIN, OP_ONE_TO_N, OP_RANGE};

    // The stored operation code selects which passes through the multiplier it needs.
    always_comb
    begin
        op_draws  = 1'b0;
        op_scales = 1'b0;
        case (op_t'(op_reg))
            OP_RAW, OP_COIN:
            begin
                op_draws = 1'b1;
            end
            OP_ONE_TO_N, OP_RANGE:
            begin
                op_draws  = 1'b1;
                op_scales = 1'b1;
            end
            default:
            begin
                op_draws  = 1'b0;
                op_scales = 1'b0;
            end
        endcase
    end

    // Both differences are formed in parallel; the sign of a - b picks the low bound.
    always_comb
    begin
        d_ab   = {a_in[31], a_in} - {b_in[31], b_in};
        d_ba   = {b_in[31], b_in} - {a_in[31], a_in};
        a_lt_b = d_ab[32];
        abs_a  = a_in[31] ? (~a_in + 32'd1) : a_in;
    end

    // The seed is reduced by a truncating remainder; a result that is not positive has
    // the modulus added. A negative seed of minus 2^31 lands one below the modulus, and
    // zero or plus or minus the modulus load the modulus itself.
    always_comb
    begin
        seed_low_m1 = a_in[STATE_W-1:0] - STATE_W'(1);
        if (!a_in[31])
        begin
            if ((a_in == '0) || (a_in[STATE_W-1:0] == MOD))
            begin
                seed_dec = MOD;
            end
            else
            begin
                seed_dec = a_in[STATE_W-1:0];
            end
        end
        else if (a_in[STATE_W-1:0] == '0)
        begin
            seed_dec = MOD - STATE_W'(1);
        end
        else if (seed_low_m1 == '0)
        begin
            seed_dec = MOD;
        end
        else
        begin
            seed_dec = seed_low_m1;
        end
    end

    // A product that is a multiple of the modulus leaves the state at the modulus.
    assign adv_state = (mm_rem == '0) ? MOD : mm_rem;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_draws)
                    begin
                        state_next = ST_ADVANCE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADVANCE:
            begin
                if (mm_status.done)
                begin
                    state_next = op_scales ? ST_SCALE : ST_DONE;
                end
            end
            ST_SCALE:
            begin
                if (mm_status.done)
                begin
                    state_next = ST_COMBINE;
                end
            end
            ST_COMBINE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: handshake and multiplier commands.
    always_comb
    begin
        s_tready     = 1'b0;
        load_out     = 1'b0;
        mm_cmd.start = 1'b0;
        mm_cmd.nbits = ADV_BITS;
        mm_mcand     = gen_state_reg;
        mm_mult      = MUL_ALIGNED;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                mm_cmd.start = s_tvalid && req_draws;
            end
            ST_ADVANCE:
            begin
                // The second pass multiplies the fresh state by the span magnitude.
                mm_cmd.start = mm_status.done && op_scales;
                mm_cmd.nbits = SPAN_BITS;
                mm_mcand     = adv_state;
                if (op_t'(op_reg) == OP_RANGE)
                begin
                    mm_mult = {1'b0, mag_reg} + MULT_W'(1);
                end
                else
                begin
                    mm_mult = {1'b0, mag_reg};
                end
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Truncation toward zero: a nonzero remainder pulls a negative base up when the
    // product is positive, and a positive base down when the product is negative.
    always_comb
    begin
        lo_ext = {{2{lo_reg[31]}}, lo_reg};
        q_ext  = {1'b0, mm_quo};
        if (rnz_reg && !sp_reg && base_reg[33])
        begin
            value_adj = base_reg + 34'd1;
        end
        else if (rnz_reg && sp_reg && !base_reg[33] && (base_reg != '0))
        begin
            value_adj = base_reg - 34'd1;
        end
        else
        begin
            value_adj = base_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_state_reg <= RESET_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (op_t'(s_tuser) == OP_SEED))
            begin
                gen_state_reg <= seed_dec;
            end
            else if ((state_reg == ST_ADVANCE) && mm_status.done)
            begin
                gen_state_reg <= adv_state;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser;
            base_reg <= '0;
            rnz_reg  <= 1'b0;
            if (op_t'(s_tuser) == OP_RANGE)
            begin
                lo_reg  <= a_lt_b ? a_in : b_in;
                mag_reg <= a_lt_b ? d_ba[31:0] : d_ab[31:0];
                sp_reg  <= 1'b0;
            end
            else
            begin
                lo_reg  <= 32'd1;
                mag_reg <= abs_a;
                sp_reg  <= a_in[31];
            end
        end
        else if ((state_reg == ST_ADVANCE) && mm_status.done)
        begin
            // A coin shows one when the fraction lies below one half.
            if (op_t'(op_reg) == OP_COIN)
            begin
                base_reg <= {33'd0, !adv_state[STATE_W-1]};
            end
            else
            begin
                base_reg <= '0;
            end
        end
        else if (state_reg == ST_COMBINE)
        begin
            base_reg <= sp_reg ? (lo_ext - q_ext) : (lo_ext + q_ext);
            rnz_reg  <= (mm_rem != '0);
        end

        if (load_out)
        begin
            out_state_reg <= gen_state_reg;
            out_value_reg <= value_adj[32:0];
        end
    end

    mrg_mulmod u_mulmod (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (mm_cmd),
        .multiplicand (mm_mcand),
        .multiplier   (mm_mult),
        .status       (mm_status),
        .rem          (mm_rem),
        .quo          (mm_quo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_state_reg};

`ifndef ASSERT_OFF
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_state_reg != '0)
        else $error("generator state reached zero");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted without leaving idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result posted outside the done state");

    a_mult_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> ((state_reg == ST_ADVANCE) || (state_reg == ST_SCALE)))
        else $error("multiplier finished while no pass was running");

    a_idle_mult_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mm_status.busy)
        else $error("multiplier still running while the sequencer is idle");
`endif

endmodule

>>> tb/sv/minstd_random_range_generator_test.sv
// Self-checking testbench for the minimal-standard random range generator.
`timescale 1ns / 100ps

module minstd_random_range_generator_test;
    import mrg_pkg::*;

    // The generator arithmetic is done in 64-bit signed integers, which hold every product.
    localparam longint MODULUS = longint'(MOD);
    localparam longint MULTIPLIER = longint'(MUL);
    localparam longint SEED_AFTER_RESET = longint'(RESET_SEED);
    localparam longint HALF_MODULUS = 64'd1 << 30;

    // Operation codes that the block must ignore.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

    localparam logic [31:0] INT_MIN_BITS = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_BITS = 32'h7FFF_FFFF;

    // Matches the packing of m_tdata: new_state in the low bits, scaled_value above it.
    typedef struct packed {
        logic [32:0] scaled_value;
        logic [30:0] new_state;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;    // [31:0] operand_a, [63:32] operand_b
    logic [2:0]  s_tuser = '0;    // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [30:0] new_state, [63:31] scaled_value

    longint       generator_state;
    draw_result_t pending_draws[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    minstd_random_range_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("minstd_random_range_generator_test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (error_count < 100)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        error_count++;
    endtask

    // Truncating scale: lo + state * span / modulus, rounded toward zero as a whole.
    function automatic longint scale_draw(input longint lo, input longint span,
                                          input longint state_now);
        return (state_now * span + lo * MODULUS) / MODULUS;
    endfunction

    // Applies one request to the generator state and returns the result it should produce.
    function automatic draw_result_t predict_draw(input logic [2:0] op,
                                                  input logic [31:0] a_bits,
                                                  input logic [31:0] b_bits);
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint value;
        draw_result_t res;
        a = $signed(a_bits);
        b = $signed(b_bits);
        value = 0;
        if (op == OP_SEED) begin
            // Seed reduction truncates toward zero; zero or negative wraps up by the modulus.
            generator_state = a % MODULUS;
            if (generator_state <= 0)
                generator_state += MODULUS;
        end else if (op <= OP_RANGE) begin
            generator_state = (generator_state * MULTIPLIER) % MODULUS;
            if (generator_state == 0)
                generator_state = MODULUS;
            if (op == OP_COIN) begin
                value = (generator_state < HALF_MODULUS) ? 1 : 0;
            end else if (op == OP_ONE_TO_N) begin
                value = scale_draw(1, a, generator_state);
            end else if (op == OP_RANGE) begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                value = scale_draw(lo, hi - lo + 1, generator_state);
            end
        end
        res.new_state = generator_state[30:0];
        res.scaled_value = value[32:0];
        return res;
    endfunction

    // Presents one request, waits for it to be taken, then records the expected result.
    task automatic send_request(input logic [2:0] op, input logic [31:0] a,
                                input logic [31:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_draws.push_back(predict_draw(op, a, b));
    endtask

    // Every result is compared against the oldest outstanding request.
    always @(posedge clk) begin
        draw_result_t want;
        draw_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_draws.size() == 0) begin
                report_mismatch("result with no request pending", '0, m_tdata);
            end else begin
                want = pending_draws.pop_front();
                if (got.new_state !== want.new_state)
                    report_mismatch("new_state", 64'(want.new_state), 64'(got.new_state));
                if (got.scaled_value !== want.scaled_value)
                    report_mismatch("scaled_value", 64'(want.scaled_value),
                                    64'(got.scaled_value));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // The first draw after reset shows the reset seed advanced once.
    task automatic test_reset_state();
        send_request(OP_RAW, $urandom(), $urandom());
    endtask

    // Seeds at zero, at the modulus, negative and at the extremes of the signed range.
    task automatic test_seed_reduction();
        send_request(OP_SEED, 32'd0, $urandom());
        send_request(OP_SEED, INT_MAX_BITS, $urandom());
        send_request(OP_SEED, 32'hFFFF_FFFF, $urandom());
        send_request(OP_SEED, INT_MIN_BITS, $urandom());
        send_request(OP_SEED, 32'd1, $urandom());
        send_request(OP_RAW, $urandom(), $urandom());
    endtask

    // A state at the modulus sticks there, gives coin zero and pushes scaling to the top.
    task automatic test_stuck_state();
        send_request(OP_SEED, 32'd0, 32'd0);
        send_request(OP_RAW, 32'd0, 32'd0);
        send_request(OP_COIN, 32'd0, 32'd0);
        send_request(OP_ONE_TO_N, INT_MAX_BITS, 32'd0);
        send_request(OP_RANGE, INT_MIN_BITS, INT_MAX_BITS);
        send_request(OP_RANGE, INT_MAX_BITS, INT_MIN_BITS);
    endtask

    // Negative and zero N, swapped and equal bounds, and the widest span.
    task automatic test_scaling_bounds();
        send_request(OP_SEED, 32'd1, 32'd0);
        send_request(OP_COIN, 32'd0, 32'd0);
        send_request(OP_ONE_TO_N, INT_MIN_BITS, $urandom());
        send_request(OP_ONE_TO_N, 32'd0, $urandom());
        send_request(OP_ONE_TO_N, -32'sd7, $urandom());
        send_request(OP_RANGE, 32'd100, -32'sd100);
        send_request(OP_RANGE, 32'd5, 32'd5);
        send_request(OP_RANGE, INT_MIN_BITS, INT_MAX_BITS);
    endtask

    // Codes above the range operation must leave the state alone.
    task automatic test_unused_opcodes();
        for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
            send_request(3'(code), $urandom(), $urandom());
    endtask

    // Operands lean toward the edges of the signed range and toward small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return INT_MIN_BITS;
            1: return INT_MAX_BITS;
            2: return 32'($signed($urandom_range(0, 32)) - 16);
            3: return 32'($urandom_range(1, 1000));
            4: return -32'($urandom_range(1, 1000));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_random_traffic(input int count);
        int pick;
        logic [31:0] seed;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Now and then the seed lands on the state that sticks.
                case ($urandom_range(0, 15))
                    0: seed = 32'd0;
                    1: seed = INT_MAX_BITS;
                    default: seed = $urandom_range(0, 1) ? $urandom() : pick_operand();
                endcase
                send_request(OP_SEED, seed, $urandom());
            end else if (pick < 12) begin
                send_request(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                             $urandom(), $urandom());
            end else if (pick < 32) begin
                send_request(OP_RAW, $urandom(), $urandom());
            end else if (pick < 52) begin
                send_request(OP_COIN, $urandom(), $urandom());
            end else if (pick < 76) begin
                send_request(OP_ONE_TO_N, pick_operand(), $urandom());
            end else begin
                send_request(OP_RANGE, pick_operand(), pick_operand());
            end
        end
    endtask

    initial begin
        generator_state = SEED_AFTER_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly while the receiver stalls most of the time.
        send_idle_pct = 32;
        recv_idle_pct = 85;
        test_reset_state();
        test_seed_reduction();
        test_stuck_state();
        test_scaling_bounds();
        test_unused_opcodes();
        test_random_traffic(320);

        send_idle_pct = 85;
        recv_idle_pct = 32;
        test_random_traffic(320);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(310);

        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (error_count == 0 && pending_draws.size() == 0)
            $display("minstd_random_range_generator_test passed");
        else
            $display("minstd_random_range_generator_test failed");
        $finish;
    end

endmodule
